FILE: hw/rtl/clpc_pkg.sv
// ----------------------------------------------------------------------------
// clpc_pkg: closest point line coefficient shared definitions
// Widths, defaults and the control record passed along the divider chain.
// ----------------------------------------------------------------------------
package clpc_pkg;

	localparam int FRACTION_BITS = 24;
	localparam int COORD_W       = 32;
	localparam int COEF_W        = 25;
	localparam int WIDE_W        = 64;
	localparam int IN_DATA_W     = 6 * COORD_W;
	localparam int OUT_DATA_W    = 32;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_ONE,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctrl_t;

endpackage

FILE: hw/rtl/clpc_front.sv
// ----------------------------------------------------------------------------
// clpc_front: projection numerator and denominator
// Four stages: coordinate differences, products, dot-product sums, then
// classification and divider operand setup.
// ----------------------------------------------------------------------------
module clpc_front #(
	parameter int FRACTION_BITS = clpc_pkg::FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ce,
	input  logic                            valid,
	input  logic [clpc_pkg::IN_DATA_W-1:0]  data,
	output clpc_pkg::ctrl_t                 ctrl_s4,
	output logic [clpc_pkg::WIDE_W-1:0]     rem_s4,
	output logic [clpc_pkg::WIDE_W-1:0]     dvsr_s4,
	output logic [FRACTION_BITS:0]          bits_s4
);

	localparam int CW = clpc_pkg::COORD_W;
	localparam int WW = clpc_pkg::WIDE_W;

	logic signed [CW-1:0] point_x, point_y, vertex_x, vertex_y, delta_x, delta_y;

	logic                 valid_s1;
	logic signed [CW-1:0] ex_s1, ey_s1, dx_s1, dy_s1;

	logic                 valid_s2;
	logic signed [WW-1:0] p1_s2, p2_s2, sx_s2, sy_s2;

	logic                 valid_s3;
	logic signed [WW:0]   num_s3;
	logic [WW-1:0]        den_s3;

	logic                 positive;
	logic [WW-1:0]        numu;
	logic                 big;
	logic [WW-1:0]        dividend;
	logic [WW-1:0]        divisor;
	clpc_pkg::kind_t      kind;

	assign point_x  = data[0*CW +: CW];
	assign point_y  = data[1*CW +: CW];
	assign vertex_x = data[2*CW +: CW];
	assign vertex_y = data[3*CW +: CW];
	assign delta_x  = data[4*CW +: CW];
	assign delta_y  = data[5*CW +: CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ex_s1  <= point_x - vertex_x;
			ey_s1  <= point_y - vertex_y;
			dx_s1  <= delta_x;
			dy_s1  <= delta_y;
			p1_s2  <= ex_s1 * dx_s1;
			p2_s2  <= ey_s1 * dy_s1;
			sx_s2  <= dx_s1 * dx_s1;
			sy_s2  <= dy_s1 * dy_s1;
			num_s3 <= {p1_s2[WW-1], p1_s2} + {p2_s2[WW-1], p2_s2};
			den_s3 <= 64'(sx_s2) + 64'(sy_s2);
		end
	end

	always_comb begin
		positive = !num_s3[WW] && (num_s3 != '0);
		numu     = num_s3[WW-1:0];
		big      = |numu[WW-1:WW-1-FRACTION_BITS];
		if (!positive) begin
			kind = clpc_pkg::KIND_ZERO;
		end else if (numu >= den_s3) begin
			kind = clpc_pkg::KIND_ONE;
		end else begin
			kind = clpc_pkg::KIND_DIV;
		end
		if (big) begin
			dividend = numu;
			divisor  = den_s3 >> FRACTION_BITS;
		end else begin
			dividend = numu << FRACTION_BITS;
			divisor  = den_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4.valid <= 1'b0;
			ctrl_s4.kind  <= clpc_pkg::KIND_ZERO;
		end else if (ce) begin
			ctrl_s4.valid <= valid_s3;
			ctrl_s4.kind  <= kind;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s4  <= dividend >> (FRACTION_BITS + 1);
			dvsr_s4 <= divisor;
			bits_s4 <= dividend[FRACTION_BITS:0];
		end
	end

endmodule

FILE: hw/rtl/clpc_cell.sv
// ----------------------------------------------------------------------------
// clpc_cell: one restoring division step
// Shift one dividend bit into the partial remainder, subtract the divisor
// when it fits and shift the quotient bit into the low end.
// ----------------------------------------------------------------------------
module clpc_cell #(
	parameter int FRACTION_BITS = clpc_pkg::FRACTION_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  clpc_pkg::ctrl_t             ctrl,
	input  logic [clpc_pkg::WIDE_W-1:0] rem,
	input  logic [clpc_pkg::WIDE_W-1:0] dvsr,
	input  logic [FRACTION_BITS:0]      bits,
	output clpc_pkg::ctrl_t             ctrl_q,
	output logic [clpc_pkg::WIDE_W-1:0] rem_q,
	output logic [clpc_pkg::WIDE_W-1:0] dvsr_q,
	output logic [FRACTION_BITS:0]      bits_q
);

	localparam int WW = clpc_pkg::WIDE_W;

	logic [WW:0]   trial;
	logic [WW:0]   diff;
	logic          fits;
	logic [WW-1:0] rem_next;

	always_comb begin
		trial    = {rem, bits[FRACTION_BITS]};
		diff     = trial - {1'b0, dvsr};
		fits     = trial >= {1'b0, dvsr};
		rem_next = fits ? diff[WW-1:0] : trial[WW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.valid <= 1'b0;
			ctrl_q.kind  <= clpc_pkg::KIND_ZERO;
		end else if (ce) begin
			ctrl_q <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_q  <= rem_next;
			dvsr_q <= dvsr;
			bits_q <= {bits[FRACTION_BITS-1:0], fits};
		end
	end

endmodule

FILE: hw/rtl/clpc_out.sv
// ----------------------------------------------------------------------------
// clpc_out: result selection and output buffering
// Pick zero, one or the quotient, then hold it in an output register with a
// skid register behind it; the chain advances only while the skid is empty.
// ----------------------------------------------------------------------------
module clpc_out #(
	parameter int FRACTION_BITS = clpc_pkg::FRACTION_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  clpc_pkg::ctrl_t             ctrl,
	input  logic [FRACTION_BITS:0]      quotient,
	input  logic                        ready,
	output logic                        ce,
	output logic                        valid,
	output logic [clpc_pkg::COEF_W-1:0] coefficient
);

	localparam int                           CF       = clpc_pkg::COEF_W;
	localparam logic [clpc_pkg::WIDE_W-1:0]  ONE_WIDE = 64'(1) << FRACTION_BITS;

	logic                        out_valid_q;
	logic [CF-1:0]               out_coef_q;
	logic                        skid_valid_q;
	logic [CF-1:0]               skid_coef_q;
	logic [clpc_pkg::WIDE_W-1:0] quot_wide;
	logic [CF-1:0]               coef;
	logic                        take;
	logic                        slot_free;

	assign quot_wide = 64'(quotient);
	assign ce        = !skid_valid_q;
	assign take      = ctrl.valid && ce;
	assign slot_free = !out_valid_q || ready;

	always_comb begin
		case (ctrl.kind)
			clpc_pkg::KIND_ZERO: coef = '0;
			clpc_pkg::KIND_ONE:  coef = ONE_WIDE[CF-1:0];
			clpc_pkg::KIND_DIV:  coef = quot_wide[CF-1:0];
			default:             coef = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_coef_q <= skid_coef_q;
			end else if (take) begin
				out_coef_q <= coef;
			end
		end else if (take) begin
			skid_coef_q <= coef;
		end
	end

	assign valid       = out_valid_q;
	assign coefficient = out_coef_q;

endmodule

FILE: hw/rtl/closest_point_line_coefficient_top.sv
// ----------------------------------------------------------------------------
// closest_point_line_coefficient_top: segment projection coefficient
// Position of a query point projected onto a segment, 0 to 1 << FRACTION_BITS.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  point, vertex and delta coordinates
// m_*      out  m_tvalid/m_tready  coefficient
//
// One transaction per cycle while the skid register is empty; the path runs through the
// four front stages, one division cell per quotient bit and the output register.
// Reset clears all valid flags and the kind fields; data registers are not reset.
// A stalled output fills the skid register, which freezes the whole chain
// and drops s_tready until the output register drains.
// ----------------------------------------------------------------------------
module closest_point_line_coefficient_top #(
	parameter int FRACTION_BITS = clpc_pkg::FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// point_x, point_y, vertex_x, vertex_y, delta_x, delta_y (32 bits each)
	input  logic [clpc_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// coefficient [24:0], zero fill [31:25]
	output logic [clpc_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int NCELL = FRACTION_BITS + 1;
	localparam int WW    = clpc_pkg::WIDE_W;
	localparam int CF    = clpc_pkg::COEF_W;

	logic                   ce;
	clpc_pkg::ctrl_t        chain_ctrl [0:NCELL];
	logic [WW-1:0]          chain_rem  [0:NCELL];
	logic [WW-1:0]          chain_dvsr [0:NCELL];
	logic [FRACTION_BITS:0] chain_bits [0:NCELL];
	logic [CF-1:0]          coefficient;

	assign s_tready = ce;

	clpc_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.valid   (s_tvalid),
		.data    (s_tdata),
		.ctrl_s4 (chain_ctrl[0]),
		.rem_s4  (chain_rem[0]),
		.dvsr_s4 (chain_dvsr[0]),
		.bits_s4 (chain_bits[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		clpc_cell #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.ctrl   (chain_ctrl[i]),
			.rem    (chain_rem[i]),
			.dvsr   (chain_dvsr[i]),
			.bits   (chain_bits[i]),
			.ctrl_q (chain_ctrl[i+1]),
			.rem_q  (chain_rem[i+1]),
			.dvsr_q (chain_dvsr[i+1]),
			.bits_q (chain_bits[i+1])
		);
	end

	clpc_out #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (chain_ctrl[NCELL]),
		.quotient    (chain_bits[NCELL]),
		.ready       (m_tready),
		.ce          (ce),
		.valid       (m_tvalid),
		.coefficient (coefficient)
	);

	assign m_tdata = {{(clpc_pkg::OUT_DATA_W - CF){1'b0}}, coefficient};

endmodule
